[design/ipc_pkg.sv]
// shared types, codes and helper functions of the ip address relation classifier
`default_nettype none

package ipc_pkg;

  // request kinds
  localparam logic MODE_LOAD     = 1'b0;
  localparam logic MODE_CLASSIFY = 1'b1;

  // relation codes
  localparam logic [2:0] REL_LOOPBACK  = 3'd0;
  localparam logic [2:0] REL_BROADCAST = 3'd1;
  localparam logic [2:0] REL_MULTICAST = 3'd2;
  localparam logic [2:0] REL_LOCAL     = 3'd3;
  localparam logic [2:0] REL_SUBNET    = 3'd4;
  localparam logic [2:0] REL_NOT_LOCAL = 3'd5;
  localparam logic [2:0] REL_LOAD      = 3'd0;

  // fixed addresses
  localparam logic [31:0] V4_LOOPBACK   = 32'h7F00_0001;
  localparam logic [31:0] V4_LIM_BCAST  = 32'hFFFF_FFFF;
  localparam logic [31:0] V4_MCAST_MASK = 32'hF000_0000;
  localparam logic [31:0] V4_MCAST_VAL  = 32'hE000_0000;
  localparam logic [7:0]  V6_MCAST_BYTE = 8'hFF;
  localparam logic [63:0] V6_LOOP_HIGH  = 64'h0;
  localparam logic [63:0] V6_LOOP_LOW   = 64'h1;

  // mask bytes walked when a load computes the ipv6 prefix length
  localparam int PFX_STEPS = 16;

  typedef struct packed {
    logic        family;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [31:0] mask_v4;
    logic [7:0]  pfx_len;
    logic        bcast_flag;
    logic [31:0] bcast_addr;
  } tbl_entry_t;

  typedef struct packed {
    logic capture;
    logic pfx_step;
    logic write;
    logic init_cls;
    logic rd_en;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // leading one bits of a byte
  function automatic logic [3:0] lead_ones8(input logic [7:0] b);
    logic [3:0] n;
    logic       run;
    n   = 4'd0;
    run = 1'b1;
    for (int k = 7; k >= 0; k--) begin
      run = run & b[k];
      if (run) n = n + 4'd1;
    end
    return n;
  endfunction

  // top n bits of a 128 bit word set
  function automatic logic [127:0] top_mask128(input logic [7:0] n);
    logic [127:0] m;
    for (int k = 0; k < 128; k++) begin
      m[127 - k] = (8'(k) < n);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[design/ip_address_relation_classifier.sv]
// classify request: fixed-address check, then one table read per entry, then the result register
// load request: a prefix walk over the netmask, one netmask byte per cycle, then the table write
// one request in flight: a new request is accepted only once the last result is produced
// a waiting result sits in the output register while the next request is accepted
// reset clears all table valid bits at once, so the block is ready right after reset
`default_nettype none

module ip_address_relation_classifier #(
  parameter int TABLE_ENTRIES = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire         mode_i,
  input  wire  [2:0]  entry_index_i,
  input  wire         is_v6_i,
  input  wire  [63:0] addr_high_i,
  input  wire  [63:0] addr_low_i,
  input  wire  [63:0] mask_high_i,
  input  wire  [63:0] mask_low_i,
  input  wire         entry_present_i,
  input  wire         has_broadcast_i,
  input  wire  [31:0] broadcast_address_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [2:0]  relation_o,
  output logic        load_ack_o
);
  import ipc_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  logic [IW-1:0] rd_addr;

  ipc_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .mode_i    (mode_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .rd_addr_o (rd_addr)
  );

  ipc_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .rd_addr_i          (rd_addr),
    .sts_o              (sts),
    .mode_i             (mode_i),
    .entry_index_i      (entry_index_i),
    .is_v6_i            (is_v6_i),
    .addr_high_i        (addr_high_i),
    .addr_low_i         (addr_low_i),
    .mask_high_i        (mask_high_i),
    .mask_low_i         (mask_low_i),
    .entry_present_i    (entry_present_i),
    .has_broadcast_i    (has_broadcast_i),
    .broadcast_address_i(broadcast_address_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .relation_o         (relation_o),
    .load_ack_o         (load_ack_o)
  );

`ifndef NO_ASSERTIONS
  // a load result always carries the zero relation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && load_ack_o) |-> (relation_o == REL_LOAD))
    else $error("load result with nonzero relation");

  // relation codes stay within the defined set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (relation_o <= REL_NOT_LOCAL))
    else $error("relation code out of range");

  // an accepted request keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while busy");

  // a new result is only produced into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("result overwrote a pending result");
`endif

endmodule

`default_nettype wire

[design/ipc_ctrl.sv]
// controller state machine of the ip address relation classifier
`default_nettype none

module ipc_ctrl #(
  parameter int TABLE_ENTRIES = 8
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  mode_i,
  output logic                 in_ready_o,
  input  ipc_pkg::dp_status_t  sts_i,
  output ipc_pkg::ctrl_cmd_t   cmd_o,
  output logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] rd_addr_o
);
  import ipc_pkg::*;

  localparam int IW      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_MAX = (TABLE_ENTRIES > PFX_STEPS) ? TABLE_ENTRIES : PFX_STEPS;
  localparam int CW      = $clog2(CNT_MAX);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PFX   = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_INIT  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cnt_d         = '0;
          state_d       = (mode_i == MODE_LOAD) ? S_PFX : S_INIT;
        end
      end
      S_PFX: begin
        cmd_o.pfx_step = 1'b1;
        cnt_d          = CW'(cnt_q + 1'b1);
        if (cnt_q == CW'(PFX_STEPS - 1)) state_d = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = S_DONE;
      end
      S_INIT: begin
        cmd_o.init_cls = 1'b1;
        cnt_d          = '0;
        state_d        = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        cnt_d       = CW'(cnt_q + 1'b1);
        if (cnt_q == CW'(TABLE_ENTRIES - 1)) state_d = S_DRAIN;
      end
      // last table read is evaluated here
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rd_addr_o = cnt_q[IW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[design/ipc_datapath.sv]
// datapath of the ip address relation classifier: request registers, table, prefix unit, result
`default_nettype none

module ipc_datapath #(
  parameter int TABLE_ENTRIES = 8
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  ipc_pkg::ctrl_cmd_t  cmd_i,
  input  wire  [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] rd_addr_i,
  output ipc_pkg::dp_status_t sts_o,
  input  wire                 mode_i,
  input  wire  [2:0]          entry_index_i,
  input  wire                 is_v6_i,
  input  wire  [63:0]         addr_high_i,
  input  wire  [63:0]         addr_low_i,
  input  wire  [63:0]         mask_high_i,
  input  wire  [63:0]         mask_low_i,
  input  wire                 entry_present_i,
  input  wire                 has_broadcast_i,
  input  wire  [31:0]         broadcast_address_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [2:0]          relation_o,
  output logic                load_ack_o
);
  import ipc_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // request registers
  logic         mode_q;
  logic [2:0]   idx_q;
  logic         v6_q;
  logic [63:0]  addr_hi_q, addr_lo_q;
  logic [31:0]  mask_v4_q;
  logic         present_q, hasb_q;
  logic [31:0]  bcast_q;

  // prefix length unit
  logic [127:0] msk_q;
  logic [7:0]   pfx_q;
  logic         pfx_stop_q;
  logic [7:0]   pfx_byte;
  logic [3:0]   pfx_lead;
  logic [7:0]   pfx_rest;

  // table
  tbl_entry_t                 tbl_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]   valid_q;
  tbl_entry_t                 rd_q;
  logic                       rd_ok_q, rd_live_q;
  tbl_entry_t                 wr_ent;
  logic [6:0]                 wr_idx;

  // scan evaluation
  logic         found_q, subnet_q;
  logic [2:0]   res_q;
  logic         spec_hit;
  logic [2:0]   spec_rel;
  logic [31:0]  a4, la4;
  logic         e_hit, e_local, e_subnet, e_bcast;
  logic [2:0]   final_rel;

  logic         out_valid_q, load_ack_q;
  logic [2:0]   relation_q;

  assign pfx_byte = msk_q[127:120];
  assign pfx_lead = lead_ones8(pfx_byte);
  assign pfx_rest = 8'(pfx_byte << pfx_lead);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q     <= mode_i;
      idx_q      <= entry_index_i;
      v6_q       <= is_v6_i;
      addr_hi_q  <= is_v6_i ? addr_high_i : 64'h0;
      addr_lo_q  <= is_v6_i ? addr_low_i : {32'h0, addr_low_i[31:0]};
      mask_v4_q  <= mask_low_i[31:0];
      present_q  <= entry_present_i;
      hasb_q     <= has_broadcast_i;
      bcast_q    <= broadcast_address_i;
      msk_q      <= {mask_high_i, mask_low_i};
      pfx_q      <= 8'd0;
      pfx_stop_q <= 1'b0;
    end else if (cmd_i.pfx_step) begin
      msk_q <= {msk_q[119:0], 8'h00};
      if (!pfx_stop_q) begin
        pfx_q <= pfx_q + {4'h0, pfx_lead};
        // a one bit below the leading ones stops the prefix count
        if (pfx_rest != 8'h00) pfx_stop_q <= 1'b1;
      end
    end
  end

  always_comb begin
    wr_ent.family     = v6_q;
    wr_ent.addr_high  = addr_hi_q;
    wr_ent.addr_low   = addr_lo_q;
    wr_ent.mask_v4    = mask_v4_q;
    wr_ent.pfx_len    = pfx_q;
    wr_ent.bcast_flag = hasb_q;
    wr_ent.bcast_addr = bcast_q;
  end

  assign wr_idx = 7'(idx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && (wr_idx < 7'(TABLE_ENTRIES))) begin
      tbl_q[IW'(idx_q)] <= wr_ent;
    end
    if (cmd_i.rd_en) begin
      rd_q <= tbl_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rd_ok_q   <= 1'b0;
      rd_live_q <= 1'b0;
    end else begin
      if (cmd_i.write && (wr_idx < 7'(TABLE_ENTRIES))) begin
        valid_q[IW'(idx_q)] <= present_q;
      end
      rd_live_q <= cmd_i.rd_en;
      rd_ok_q   <= cmd_i.rd_en & valid_q[rd_addr_i];
    end
  end

  // fixed addresses checked ahead of the table
  assign a4 = addr_lo_q[31:0];
  always_comb begin
    spec_hit = 1'b0;
    spec_rel = REL_NOT_LOCAL;
    if (!v6_q) begin
      if (a4 == V4_LOOPBACK) begin
        spec_hit = 1'b1;
        spec_rel = REL_LOOPBACK;
      end else if (a4 == V4_LIM_BCAST) begin
        spec_hit = 1'b1;
        spec_rel = REL_BROADCAST;
      end else if ((a4 & V4_MCAST_MASK) == V4_MCAST_VAL) begin
        spec_hit = 1'b1;
        spec_rel = REL_MULTICAST;
      end
    end else begin
      if (addr_hi_q == V6_LOOP_HIGH && addr_lo_q == V6_LOOP_LOW) begin
        spec_hit = 1'b1;
        spec_rel = REL_LOOPBACK;
      end else if (addr_hi_q[63:56] == V6_MCAST_BYTE) begin
        spec_hit = 1'b1;
        spec_rel = REL_MULTICAST;
      end
    end
  end

  assign la4   = rd_q.addr_low[31:0];
  assign e_hit = rd_live_q & rd_ok_q & (rd_q.family == v6_q);

  always_comb begin
    if (v6_q) begin
      e_local  = (rd_q.addr_high == addr_hi_q) && (rd_q.addr_low == addr_lo_q);
      e_subnet = ((({rd_q.addr_high, rd_q.addr_low} ^ {addr_hi_q, addr_lo_q})
                  & top_mask128(rd_q.pfx_len)) == 128'h0);
      e_bcast  = 1'b0;
    end else begin
      e_local  = (la4 == a4);
      e_subnet = ((la4 & rd_q.mask_v4) == (a4 & rd_q.mask_v4));
      e_bcast  = rd_q.bcast_flag && (rd_q.bcast_addr == a4);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_cls) begin
      found_q  <= spec_hit;
      res_q    <= spec_rel;
      subnet_q <= 1'b0;
    end else if (e_hit) begin
      // a fixed-address hit or the first local or broadcast entry decides; later hits do not
      if (!found_q) begin
        if (e_local) begin
          found_q <= 1'b1;
          res_q   <= REL_LOCAL;
        end else if (e_bcast) begin
          found_q <= 1'b1;
          res_q   <= REL_BROADCAST;
        end
      end
      if (e_subnet) subnet_q <= 1'b1;
    end
  end

  always_comb begin
    if (mode_q == MODE_LOAD) final_rel = REL_LOAD;
    else if (found_q)        final_rel = res_q;
    else if (subnet_q)       final_rel = REL_SUBNET;
    else                     final_rel = REL_NOT_LOCAL;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      relation_q <= final_rel;
      load_ack_q <= (mode_q == MODE_LOAD);
    end
  end

  assign sts_o.out_free = ~out_valid_q | out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign relation_o     = relation_q;
  assign load_ack_o     = load_ack_q;

endmodule

`default_nettype wire
